[rtl/core/tec_pkg.sv]
// Shared types and constants for the tab expand/compress block.
// Used by every module under rtl/core; depends on nothing.
package tec_pkg;

  localparam int TAB_WIDTH_DEF = 8;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic item_done;
  } ctrl_sts_t;

endpackage

[rtl/core/tec_datapath.sv]
// Datapath: mode register, column and held-space counters, request latch
// and output register. Depends on tec_pkg; driven by tec_controller.
module tec_datapath #(
  parameter int TAB_WIDTH = tec_pkg::TAB_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_mode,
  input  tec_pkg::in_item_t    in_data,
  input  tec_pkg::ctrl_cmd_t   cmd,
  output tec_pkg::ctrl_sts_t   sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tec_pkg::out_item_t   out_data
);

  localparam int CW = $clog2(TAB_WIDTH);

  logic              mode;
  tec_pkg::in_item_t item;
  logic [CW-1:0]     col;
  logic [CW-1:0]     col_next;
  logic [CW-1:0]     held;
  logic [CW-1:0]     held_next;
  logic [CW-1:0]     col_inc;
  logic [CW:0]       run_sum;
  logic              emit;
  logic [7:0]        emit_ch;
  logic              emit_last;
  logic              done;

  assign col_inc = (col == CW'(TAB_WIDTH - 1)) ? '0 : col + CW'(1);
  assign run_sum = {1'b0, col} + {1'b0, held} + (CW+1)'(1);

  always_comb begin
    col_next  = col;
    held_next = held;
    emit      = 1'b0;
    emit_ch   = tec_pkg::CH_SPACE;
    emit_last = 1'b0;
    done      = 1'b0;
    if (item.end_of_input) begin
      if (held != '0) begin
        emit      = 1'b1;
        held_next = held - CW'(1);
        col_next  = col_inc;
        if (held == CW'(1)) begin
          emit_last = 1'b1;
          done      = 1'b1;
          col_next  = '0;
        end
      end else begin
        done     = 1'b1;
        col_next = '0;
      end
    end else if (mode && item.char_in == tec_pkg::CH_SPACE) begin
      done = 1'b1;
      if (run_sum >= (CW+1)'(TAB_WIDTH)) begin
        emit      = 1'b1;
        emit_ch   = tec_pkg::CH_TAB;
        emit_last = 1'b1;
        held_next = '0;
        col_next  = '0;
      end else begin
        held_next = held + CW'(1);
      end
    end else if (held != '0) begin
      emit      = 1'b1;
      held_next = held - CW'(1);
      col_next  = col_inc;
    end else if (!mode && item.char_in == tec_pkg::CH_TAB) begin
      emit      = 1'b1;
      col_next  = col_inc;
      emit_last = (col == CW'(TAB_WIDTH - 1));
      done      = emit_last;
    end else begin
      emit      = 1'b1;
      emit_ch   = item.char_in;
      emit_last = 1'b1;
      done      = 1'b1;
      if (item.char_in == tec_pkg::CH_NL || item.char_in == tec_pkg::CH_TAB) begin
        col_next = '0;
      end else begin
        col_next = col_inc;
      end
    end
  end

  assign sts.slot_free = !out_valid || out_ready;
  assign sts.item_done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      col       <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_mode;
      end
      if (cmd.step) begin
        col  <= col_next;
        held <= held_next;
      end
      if (cmd.step && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.step && emit) begin
      out_data.char_out    <= emit_ch;
      out_data.last_of_run <= emit_last;
    end
  end

endmodule

[rtl/core/tec_controller.sv]
// Controller: takes one request at a time and steps the datapath until the
// request's results are sent. Depends on tec_pkg.
module tec_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output tec_pkg::ctrl_cmd_t cmd,
  input  tec_pkg::ctrl_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WORK = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);
  assign cmd.load = in_ready && in_valid;
  assign cmd.step = (state == S_WORK) && sts.slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (cmd.step && sts.item_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/tab_expand_compress.sv]
// Top level of the tab expand/compress block.
// Depends on tec_pkg, tec_controller and tec_datapath.
//
// One byte request at a time is taken, then one result is produced per cycle
// that the output register is free. A tab expanded at column c gives
// TAB_WIDTH - c spaces, and any held spaces are sent ahead of a byte; a
// request may also give no result. The output register frees the input
// side as soon as the last result is loaded, so a new request may be taken
// while that result waits.
// The mode register is written through cfg and is always ready; write it
// only while no request is in flight.
module tab_expand_compress #(
  parameter int TAB_WIDTH = tec_pkg::TAB_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  tec_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tec_pkg::out_item_t out_data
);

  tec_pkg::ctrl_cmd_t cmd;
  tec_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  tec_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tec_datapath #(
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_mode  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/core/tec_checker.sv]
// Port-level checks for tab_expand_compress, attached by bind.
// Depends on tec_pkg.
module tec_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tec_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous request still in work");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind tab_expand_compress tec_checker u_tec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/tab_expand_compress_test.sv]
// Self-checking testbench for tab_expand_compress: tab expansion and space compression.
// Depends on tec_pkg and the tab_expand_compress RTL; a local predictor checks each result.
`timescale 1ns / 100ps

module tab_expand_compress_test;

  localparam int TAB_W = tec_pkg::TAB_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 100000;
  localparam logic MODE_EXPAND = 1'b0;
  localparam logic MODE_COMPRESS = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tec_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tec_pkg::out_item_t out_data;

  tec_pkg::out_item_t expected_chars[$];
  logic mode_q = MODE_EXPAND;
  logic [2:0] col_q = '0;
  logic [2:0] held_q = '0;
  int errors = 0;
  int cycles = 0;
  int rx_hold_cycles = 0;
  bit idle_on = 1'b1;

  tab_expand_compress #(.TAB_WIDTH(TAB_W)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void push_char(logic [7:0] ch);
    tec_pkg::out_item_t r;
    r.char_out = ch;
    r.last_of_run = 1'b0;
    expected_chars.push_back(r);
  endfunction

  function automatic void flush_spaces();
    while (held_q != 0) begin
      push_char(tec_pkg::CH_SPACE);
      held_q = held_q - 3'd1;
      col_q = 3'((int'(col_q) + 1) % TAB_W);
    end
  endfunction

  function automatic void predict_chars(logic [7:0] ch, logic eoi);
    int n0;
    int n;
    tec_pkg::out_item_t r;
    n0 = expected_chars.size();
    if (eoi) begin
      flush_spaces();
      col_q = '0;
      held_q = '0;
    end else if (mode_q == MODE_COMPRESS && ch == tec_pkg::CH_SPACE) begin
      if (int'(col_q) + int'(held_q) + 1 >= TAB_W) begin
        push_char(tec_pkg::CH_TAB);
        held_q = '0;
        col_q = '0;
      end else begin
        held_q = held_q + 3'd1;
      end
    end else begin
      flush_spaces();
      if (mode_q == MODE_EXPAND && ch == tec_pkg::CH_TAB) begin
        for (n = TAB_W - int'(col_q); n > 0; n--) push_char(tec_pkg::CH_SPACE);
        col_q = '0;
      end else begin
        push_char(ch);
        if (ch == tec_pkg::CH_NL || ch == tec_pkg::CH_TAB) col_q = '0;
        else col_q = 3'((int'(col_q) + 1) % TAB_W);
      end
    end
    if (expected_chars.size() > n0) begin
      r = expected_chars.pop_back();
      r.last_of_run = 1'b1;
      expected_chars.push_back(r);
    end
  endfunction

  // hold off for a requested stretch, otherwise stall at random while idle_on is set
  initial begin : receiver
    int hold;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= !(idle_on && $urandom_range(99) < 29);
    end
  end

  always @(posedge clk) begin
    tec_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h/%b", $time,
                 out_data.char_out, out_data.last_of_run);
      end else begin
        want = expected_chars.pop_front();
        if (out_data.char_out !== want.char_out) begin
          errors++;
          $display("%0t: char_out expected %h actual %h", $time,
                   want.char_out, out_data.char_out);
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          errors++;
          $display("%0t: last_of_run expected %b actual %b", $time,
                   want.last_of_run, out_data.last_of_run);
        end
      end
    end
  end

  task automatic send_item(logic [7:0] ch, logic eoi);
    while (idle_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_in: ch, end_of_input: eoi};
    do @(posedge clk); while (!in_ready);
    predict_chars(ch, eoi);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_q = m;
  endtask

  function automatic tec_pkg::in_item_t rand_item();
    tec_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.char_in = 8'($urandom_range(33, 126));
    it.end_of_input = 1'b0;
    if (pick < 32) it.char_in = tec_pkg::CH_SPACE;
    else if (pick < 42) it.char_in = tec_pkg::CH_TAB;
    else if (pick < 50) it.char_in = tec_pkg::CH_NL;
    else if (pick < 54) begin
      it.end_of_input = 1'b1;
      it.char_in = 8'($urandom);
    end else if (pick < 64) it.char_in = 8'($urandom);
    return it;
  endfunction

  task automatic send_random(int count);
    tec_pkg::in_item_t it;
    repeat (count) begin
      it = rand_item();
      send_item(it.char_in, it.end_of_input);
    end
  endtask

  task automatic test_expand();
    write_mode(MODE_EXPAND);
    send_item("a", 1'b0);
    send_item(tec_pkg::CH_TAB, 1'b0);
    send_item(tec_pkg::CH_TAB, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(tec_pkg::CH_NL, 1'b0);
    send_item(8'hFF, 1'b1);
    drain();
  endtask

  task automatic test_compress();
    write_mode(MODE_COMPRESS);
    send_item("q", 1'b0);
    send_item(tec_pkg::CH_SPACE, 1'b0);
    send_item(tec_pkg::CH_SPACE, 1'b0);
    send_item("r", 1'b0);
    send_item("s", 1'b0);
    send_item("t", 1'b0);
    send_item("u", 1'b0);
    send_item(tec_pkg::CH_SPACE, 1'b0);
    send_item(tec_pkg::CH_SPACE, 1'b0);
    send_item(tec_pkg::CH_TAB, 1'b0);
    send_item(tec_pkg::CH_SPACE, 1'b0);
    send_item(tec_pkg::CH_SPACE, 1'b0);
    send_item(8'h00, 1'b1);
    drain();
  endtask

  task automatic test_mode_switch();
    write_mode(MODE_COMPRESS);
    send_item(tec_pkg::CH_SPACE, 1'b0);
    send_item(tec_pkg::CH_SPACE, 1'b0);
    drain();
    write_mode(MODE_EXPAND);
    send_item(tec_pkg::CH_TAB, 1'b0);
    drain();
    write_mode(MODE_COMPRESS);
    send_item(tec_pkg::CH_SPACE, 1'b0);
    drain();
    write_mode(MODE_EXPAND);
    send_item("z", 1'b0);
    drain();
  endtask

  task automatic test_random();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      write_mode(phase % 2 == 0 ? MODE_COMPRESS : MODE_EXPAND);
      idle_on = (phase != 2);
      send_random(16);
      drain();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    write_mode(MODE_EXPAND);
    rx_hold_cycles = 120;
    send_random(16);
    drain();
    write_mode(MODE_COMPRESS);
    send_random(8);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_expand();
    test_compress();
    test_mode_switch();
    test_random();
    test_backpressure();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
